[hdl/work_stealing_task_queue_defines.svh]
// Assertion helpers shared by the queue RTL.
`ifndef WORK_STEALING_TASK_QUEUE_DEFINES_SVH
`define WORK_STEALING_TASK_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define WSTQ_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define WSTQ_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

[hdl/wstq_pkg.sv]
`timescale 1ns / 1ps

package wstq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 2;
    localparam int TASK_W   = 32;
    localparam int QC_W     = 5;

    typedef enum logic [OP_W-1:0] {
        OP_SUBMIT = 2'd0,
        OP_FETCH  = 2'd1,
        OP_STEAL  = 2'd2
    } t_op;

    // Decoded request, produced at accept time from the pointer state.
    typedef struct packed {
        logic [IDX_W-1:0] rd_head;
        logic [IDX_W-1:0] rd_next;
        logic             stored;
        logic             take_head;
        logic             take_second;
        logic [IDX_W-1:0] wr_addr;
        logic [CNT_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [TASK_W-1:0] data;
    } t_wr;

endpackage

[hdl/wstq_ctrl.sv]
`timescale 1ns / 1ps
`include "work_stealing_task_queue_defines.svh"

module wstq_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [wstq_pkg::OP_W-1:0]  i_operation,
    output wstq_pkg::t_cmd             o_cmd
);

    localparam int IDX_W    = wstq_pkg::IDX_W;
    localparam int CNT_W    = wstq_pkg::CNT_W;
    localparam int CAPACITY = wstq_pkg::CAPACITY;

    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] n_head;
    logic [IDX_W-1:0] n_tail;
    logic [CNT_W-1:0] n_count;

    logic [IDX_W-1:0] w_head_next;
    logic [IDX_W-1:0] w_tail_next;
    logic             w_submit;
    logic             w_fetch;
    logic             w_steal;

    assign w_head_next = (r_head == IDX_W'(CAPACITY - 1)) ? '0 : r_head + 1'b1;
    assign w_tail_next = (r_tail == IDX_W'(CAPACITY - 1)) ? '0 : r_tail + 1'b1;

    assign w_submit = (i_operation == wstq_pkg::OP_SUBMIT) && (r_count != CNT_W'(CAPACITY));
    assign w_fetch  = (i_operation == wstq_pkg::OP_FETCH)  && (r_count != '0);
    assign w_steal  = (i_operation == wstq_pkg::OP_STEAL)  && (r_count >= CNT_W'(2));

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (w_submit) begin
            n_tail  = w_tail_next;
            n_count = r_count + 1'b1;
        end
        if (w_fetch || w_steal) begin
            n_head  = w_head_next;
            n_count = r_count - 1'b1;
        end
    end

    // A steal copies the head into the second slot, so the write lands on head+1.
    always_comb begin
        o_cmd.rd_head     = r_head;
        o_cmd.rd_next     = w_head_next;
        o_cmd.stored      = w_submit;
        o_cmd.take_head   = w_fetch;
        o_cmd.take_second = w_steal;
        o_cmd.wr_addr     = w_submit ? r_tail : w_head_next;
        o_cmd.count       = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    `WSTQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(CAPACITY), "count above capacity")
    `WSTQ_ASSERT_IMP(a_ptr_meet, i_clk, i_rst_n,
        (r_count == '0) || (r_count == CNT_W'(CAPACITY)), r_head == r_tail,
        "head and tail disagree when empty or full")
    `WSTQ_ASSERT_NXT(a_unused_op, i_clk, i_rst_n,
        i_accept && (i_operation != wstq_pkg::OP_SUBMIT)
            && (i_operation != wstq_pkg::OP_FETCH) && (i_operation != wstq_pkg::OP_STEAL),
        $stable(r_count) && $stable(r_head) && $stable(r_tail), "unused op changed state")

endmodule

[hdl/wstq_slots.sv]
`timescale 1ns / 1ps

module wstq_slots (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [wstq_pkg::IDX_W-1:0]   i_rd_head,
    input  logic [wstq_pkg::IDX_W-1:0]   i_rd_next,
    input  wstq_pkg::t_wr                i_wr,
    output logic [wstq_pkg::TASK_W-1:0]  o_rd_head_data,
    output logic [wstq_pkg::TASK_W-1:0]  o_rd_next_data
);

    logic [wstq_pkg::TASK_W-1:0] r_mem [wstq_pkg::CAPACITY];
    logic [wstq_pkg::TASK_W-1:0] r_rd_head_data;
    logic [wstq_pkg::TASK_W-1:0] r_rd_next_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // The write of the previous request lands on this same edge: bypass it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_head_data <= (i_wr.en && (i_wr.addr == i_rd_head)) ? i_wr.data
                                                                     : r_mem[i_rd_head];
            r_rd_next_data <= (i_wr.en && (i_wr.addr == i_rd_next)) ? i_wr.data
                                                                     : r_mem[i_rd_next];
        end
    end

    assign o_rd_head_data = r_rd_head_data;
    assign o_rd_next_data = r_rd_next_data;

endmodule

[hdl/work_stealing_task_queue.sv]
// Work-stealing task queue: a 16-entry ring of 32-bit task handles. Each request
// (submit, fetch from head, steal the second entry) yields exactly one result that
// carries the removed handle, its valid flag, the submit acceptance flag and the
// count left queued. One request is taken every cycle when the result side keeps
// up; a result passes through the registered read of the slot memory and then the
// result register. Pointers and count are updated at accept time, so back-to-back
// requests never wait on each other.
`timescale 1ns / 1ps
`include "work_stealing_task_queue_defines.svh"

module work_stealing_task_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [wstq_pkg::OP_W-1:0]    i_operation,
    input  logic [wstq_pkg::TASK_W-1:0]  i_task_handle,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [wstq_pkg::TASK_W-1:0]  o_task_out,
    output logic                         o_task_valid,
    output logic                         o_accepted,
    output logic [wstq_pkg::QC_W-1:0]    o_queue_count
);

    localparam int QC_W = wstq_pkg::QC_W;

    logic                         w_accept;
    logic                         w_s2_go;
    wstq_pkg::t_cmd               w_cmd;
    wstq_pkg::t_wr                w_wr;
    logic [wstq_pkg::TASK_W-1:0]  w_rd_head_data;
    logic [wstq_pkg::TASK_W-1:0]  w_rd_next_data;
    logic [wstq_pkg::TASK_W-1:0]  n_task_out;

    logic                         r_s2_v;
    wstq_pkg::t_cmd               r_s2_cmd;
    logic [wstq_pkg::TASK_W-1:0]  r_s2_handle;
    logic                         r_wr_pend;
    logic                         r_out_v;
    logic [wstq_pkg::TASK_W-1:0]  r_task_out;
    logic                         r_task_valid;
    logic                         r_accepted;
    logic [QC_W-1:0]              r_qcount;

    assign w_s2_go  = r_s2_v && (!r_out_v || i_ready);
    assign o_ready  = !r_s2_v || w_s2_go;
    assign w_accept = i_valid && o_ready;

    wstq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_operation (i_operation),
        .o_cmd       (w_cmd)
    );

    // Slot write happens in the cycle after the request is accepted; a steal needs the head value first.
    always_comb begin
        w_wr.en   = r_wr_pend;
        w_wr.addr = r_s2_cmd.wr_addr;
        w_wr.data = r_s2_cmd.stored ? r_s2_handle : w_rd_head_data;
    end

    wstq_slots u_slots (
        .i_clk          (i_clk),
        .i_rd_en        (w_accept),
        .i_rd_head      (w_cmd.rd_head),
        .i_rd_next      (w_cmd.rd_next),
        .i_wr           (w_wr),
        .o_rd_head_data (w_rd_head_data),
        .o_rd_next_data (w_rd_next_data)
    );

    always_comb begin
        priority if (r_s2_cmd.take_head) begin
            n_task_out = w_rd_head_data;
        end else if (r_s2_cmd.take_second) begin
            n_task_out = w_rd_next_data;
        end else begin
            n_task_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v    <= 1'b0;
            r_wr_pend <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_wr_pend <= w_accept && (w_cmd.stored || w_cmd.take_second);
            if (w_accept) begin
                r_s2_v <= 1'b1;
            end else if (w_s2_go) begin
                r_s2_v <= 1'b0;
            end
            if (w_s2_go) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s2_cmd    <= w_cmd;
            r_s2_handle <= i_task_handle;
        end
        if (w_s2_go) begin
            r_task_out   <= n_task_out;
            r_task_valid <= r_s2_cmd.take_head || r_s2_cmd.take_second;
            r_accepted   <= r_s2_cmd.stored;
            r_qcount     <= QC_W'(r_s2_cmd.count);
        end
    end

    assign o_valid       = r_out_v;
    assign o_task_out    = r_task_out;
    assign o_task_valid  = r_task_valid;
    assign o_accepted    = r_accepted;
    assign o_queue_count = r_qcount;

    `WSTQ_ASSERT_NXT(a_wr_once, i_clk, i_rst_n, r_wr_pend && !w_accept,
        !r_wr_pend, "slot write repeated")
    `WSTQ_ASSERT_IMP(a_out_kind, i_clk, i_rst_n, o_valid,
        !(o_task_valid && o_accepted), "result both removed and stored")

endmodule
